// ===== rtl/srw_pkg.sv =====
// Package for the selective-repeat receive window: sizes, codes, beat types
// and the modular wrap helper shared by the front and back parts.
// Depends on nothing.
`default_nettype none

package srw_pkg;

    localparam int WINDOW_SLOTS  = 10;
    localparam int SEGMENT_BYTES = 512;
    localparam int SEQ_SPACE     = 25601;
    localparam int QUEUE_DEPTH   = 2;

    localparam int SEQ_W   = 15;
    localparam int LEN_W   = 10;
    localparam int SLOT_W  = 4;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = SEQ_W + LEN_W;

    localparam int SPAN      = WINDOW_SLOTS * SEGMENT_BYTES;
    localparam int SEG_SHIFT = $clog2(SEGMENT_BYTES);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - (2 * SEQ_W + SLOT_W + LEN_W);

    localparam logic [SEQ_W:0]   SEQ_SPACE_V = (SEQ_W + 1)'(SEQ_SPACE);
    localparam logic [SEQ_W:0]   SPAN_V      = (SEQ_W + 1)'(SPAN);
    localparam logic [LEN_W-1:0] SEG_BYTES_V = LEN_W'(SEGMENT_BYTES);

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW_ACK = 2'd0,
        KIND_DUP_ACK = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_FIN_ACK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_CLASSIFY,
        ST_FIN,
        ST_DEL_RD,
        ST_DEL_CHK
    } back_state_t;

    // One received header after reduction and length saturation.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] own;
        logic [LEN_W-1:0] len;
        logic             fin;
    } seg_t;

    // One result beat.
    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  ack;
        logic [SEQ_W-1:0]  own;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  dlen;
        logic              last;
    } result_t;

    // Reduces a value below twice the sequence space into the space.
    function automatic logic [SEQ_W-1:0] seq_wrap(input logic [SEQ_W:0] v);
        logic [SEQ_W:0] r;
        r = (v >= SEQ_SPACE_V) ? (v - SEQ_SPACE_V) : v;
        return r[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/srw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module srw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/srw_front.sv =====
// Front part: accepts header beats, reduces the numbers into the sequence
// space, saturates the length and queues the result. Depends on srw_pkg.
`default_nettype none

module srw_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [srw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]                     s_tuser,
    output logic                                q_valid,
    input  wire logic                           q_ready,
    output srw_pkg::seg_t                       q_seg
);

    localparam int PTR_W = (srw_pkg::QUEUE_DEPTH > 1) ? $clog2(srw_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(srw_pkg::QUEUE_DEPTH + 1);

    srw_pkg::seg_t    seg_in;
    srw_pkg::seg_t    q_mem_reg [srw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    logic [srw_pkg::LEN_W-1:0] raw_len;

    assign raw_len = s_tdata[2*srw_pkg::SEQ_W +: srw_pkg::LEN_W];

    always_comb
    begin
        seg_in.seq = srw_pkg::seq_wrap({1'b0, s_tdata[0 +: srw_pkg::SEQ_W]});
        seg_in.own = srw_pkg::seq_wrap({1'b0, s_tdata[srw_pkg::SEQ_W +: srw_pkg::SEQ_W]});
        seg_in.len = (raw_len > srw_pkg::SEG_BYTES_V) ? srw_pkg::SEG_BYTES_V : raw_len;
        seg_in.fin = s_tuser[0];
    end

    assign s_tready = (count_reg != CNT_W'(srw_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_seg    = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(srw_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(srw_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= seg_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srw_back.sv =====
// Back part: scans the slot store for duplicates, classifies each header,
// stores new segments and walks in-order deliveries into the result register.
// Depends on srw_pkg and srw_ram.
`default_nettype none

module srw_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [srw_pkg::SEQ_W-1:0]    cfg_wr_data,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire srw_pkg::seg_t                q_seg,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output srw_pkg::result_t                  res
);

    localparam int NS  = srw_pkg::WINDOW_SLOTS;
    localparam int SW  = srw_pkg::SLOT_W;
    localparam int QW  = srw_pkg::SEQ_W;
    localparam int LW  = srw_pkg::LEN_W;

    srw_pkg::back_state_t state_reg, state_next;
    srw_pkg::seg_t        cur_reg, cur_next;
    srw_pkg::result_t     out_reg, out_next;
    logic                 out_vld_reg, out_vld_next, out_load;

    logic [SW-1:0] scan_idx_reg, scan_idx_next;
    logic [SW-1:0] chk_idx_reg, chk_idx_next;
    logic          chk_vld_reg, chk_vld_next;
    logic          dup_reg, dup_next;
    logic [QW-1:0] d_reg, d_next;
    logic [NS-1:0] slot_valid_reg, slot_valid_next;
    logic [SW-1:0] ws_reg, ws_next;
    logic [QW-1:0] base_reg, base_next;
    logic [QW-1:0] last_ack_reg, last_ack_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [SW-1:0] pend_slot_reg, pend_slot_next;
    logic [LW-1:0] pend_len_reg, pend_len_next;

    logic                           ram_we;
    logic [SW-1:0]                  ram_waddr, ram_raddr;
    logic [srw_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata;
    logic [QW-1:0]                  rd_seq;
    logic [LW-1:0]                  rd_len;

    logic [QW:0]   diff;
    logic          in_win, near_behind, tgt_busy, is_dup, drop, store, deliver_first;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] tgt_slot, ws_inc;
    logic [QW-1:0] ack_val, fin_ack, base_add;
    logic          hit, out_free, del_adv;

    srw_ram #(
        .WIDTH (srw_pkg::ENTRY_W),
        .DEPTH (NS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_seq = ram_rdata[LW +: QW];
    assign rd_len = ram_rdata[LW-1:0];

    // Offset of the current header from the window base, in sequence space.
    assign diff = {1'b0, cur_reg.seq}
                + ((cur_reg.seq >= base_reg) ? '0 : srw_pkg::SEQ_SPACE_V)
                - {1'b0, base_reg};

    assign in_win      = ({1'b0, d_reg} < srw_pkg::SPAN_V);
    assign near_behind = (({1'b0, d_reg} + srw_pkg::SPAN_V) >= srw_pkg::SEQ_SPACE_V);
    assign slot_sum    = {1'b0, ws_reg} + {1'b0, SW'(d_reg >> srw_pkg::SEG_SHIFT)};
    assign tgt_slot    = (slot_sum >= (SW + 1)'(NS)) ? SW'(slot_sum - (SW + 1)'(NS))
                                                     : SW'(slot_sum);
    assign tgt_busy    = slot_valid_reg[tgt_slot];
    assign is_dup      = dup_reg || (in_win && tgt_busy) || (!in_win && near_behind);
    assign drop        = !dup_reg && !in_win && !near_behind;
    assign store       = !is_dup && in_win && (cur_reg.len != '0);
    // A stored segment starts a delivery run only when it sits exactly at base.
    assign deliver_first = store && (d_reg == '0);

    assign ack_val  = srw_pkg::seq_wrap({1'b0, cur_reg.seq}
                                        + {{(QW + 1 - LW){1'b0}}, cur_reg.len});
    assign fin_ack  = (last_ack_reg == QW'(srw_pkg::SEQ_SPACE - 1)) ? '0
                                                                    : last_ack_reg + QW'(1);
    assign hit      = slot_valid_reg[ws_reg] && (rd_seq == base_reg);
    assign base_add = srw_pkg::seq_wrap({1'b0, base_reg} + {{(QW + 1 - LW){1'b0}}, rd_len});
    assign ws_inc   = (ws_reg == SW'(NS - 1)) ? '0 : ws_reg + SW'(1);
    assign out_free = !out_vld_reg || m_tready;
    assign del_adv  = !pend_vld_reg || out_free;

    assign m_tvalid = out_vld_reg;
    assign res      = out_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srw_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_seg.fin ? srw_pkg::ST_FIN : srw_pkg::ST_SCAN;
                end
            end
            srw_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == SW'(NS - 1))
                begin
                    state_next = srw_pkg::ST_SCAN_LAST;
                end
            end
            srw_pkg::ST_SCAN_LAST:
            begin
                state_next = srw_pkg::ST_CLASSIFY;
            end
            srw_pkg::ST_CLASSIFY:
            begin
                if (drop)
                begin
                    state_next = srw_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    state_next = deliver_first ? srw_pkg::ST_DEL_RD : srw_pkg::ST_IDLE;
                end
            end
            srw_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = srw_pkg::ST_IDLE;
                end
            end
            srw_pkg::ST_DEL_RD:
            begin
                state_next = srw_pkg::ST_DEL_CHK;
            end
            srw_pkg::ST_DEL_CHK:
            begin
                if (del_adv)
                begin
                    state_next = hit ? srw_pkg::ST_DEL_RD : srw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        q_ready         = 1'b0;
        cur_next        = cur_reg;
        scan_idx_next   = scan_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = 1'b0;
        dup_next        = dup_reg;
        d_next          = d_reg;
        slot_valid_next = slot_valid_reg;
        ws_next         = ws_reg;
        base_next       = base_reg;
        last_ack_next   = last_ack_reg;
        pend_vld_next   = pend_vld_reg;
        pend_slot_next  = pend_slot_reg;
        pend_len_next   = pend_len_reg;
        ram_we          = 1'b0;
        ram_waddr       = tgt_slot;
        ram_wdata       = {cur_reg.seq, cur_reg.len};
        ram_raddr       = (state_reg == srw_pkg::ST_SCAN) ? scan_idx_reg : ws_reg;
        out_load        = 1'b0;
        out_next        = out_reg;

        // Pipelined duplicate compare, one slot behind the read address.
        if (chk_vld_reg && slot_valid_reg[chk_idx_reg] && (rd_seq == cur_reg.seq))
        begin
            dup_next = 1'b1;
        end

        case (state_reg)
            srw_pkg::ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cur_next      = q_seg;
                    scan_idx_next = '0;
                    dup_next      = 1'b0;
                end
            end
            srw_pkg::ST_SCAN:
            begin
                chk_vld_next  = 1'b1;
                chk_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + SW'(1);
                d_next        = diff[QW-1:0];
            end
            srw_pkg::ST_CLASSIFY:
            begin
                if (!drop && out_free)
                begin
                    out_load      = 1'b1;
                    out_next.kind = is_dup ? srw_pkg::KIND_DUP_ACK : srw_pkg::KIND_NEW_ACK;
                    out_next.ack  = ack_val;
                    out_next.own  = cur_reg.own;
                    out_next.slot = store ? tgt_slot : '0;
                    out_next.dlen = '0;
                    out_next.last = !deliver_first;
                    last_ack_next = ack_val;
                    if (store)
                    begin
                        ram_we                    = 1'b1;
                        slot_valid_next[tgt_slot] = 1'b1;
                    end
                end
            end
            srw_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_next.kind = srw_pkg::KIND_FIN_ACK;
                    out_next.ack  = fin_ack;
                    out_next.own  = cur_reg.own;
                    out_next.slot = '0;
                    out_next.dlen = '0;
                    out_next.last = 1'b1;
                    last_ack_next = fin_ack;
                end
            end
            srw_pkg::ST_DEL_CHK:
            begin
                // A delivery is held back one step so that its last flag is known.
                if (del_adv)
                begin
                    if (pend_vld_reg)
                    begin
                        out_load      = 1'b1;
                        out_next.kind = srw_pkg::KIND_DELIVER;
                        out_next.ack  = '0;
                        out_next.own  = '0;
                        out_next.slot = pend_slot_reg;
                        out_next.dlen = pend_len_reg;
                        out_next.last = !hit;
                    end
                    if (hit)
                    begin
                        pend_vld_next           = 1'b1;
                        pend_slot_next          = ws_reg;
                        pend_len_next           = rd_len;
                        slot_valid_next[ws_reg] = 1'b0;
                        base_next               = base_add;
                        ws_next                 = ws_inc;
                    end
                    else
                    begin
                        pend_vld_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else
        begin
            out_vld_next = out_vld_reg && !m_tready;
        end

        if (cfg_wr_en)
        begin
            base_next       = srw_pkg::seq_wrap({1'b0, cfg_wr_data});
            last_ack_next   = srw_pkg::seq_wrap({1'b0, cfg_wr_data});
            slot_valid_next = '0;
            ws_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srw_pkg::ST_IDLE;
            chk_vld_reg    <= 1'b0;
            dup_reg        <= 1'b0;
            slot_valid_reg <= '0;
            ws_reg         <= '0;
            base_reg       <= '0;
            last_ack_reg   <= '0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_vld_reg    <= chk_vld_next;
            dup_reg        <= dup_next;
            slot_valid_reg <= slot_valid_next;
            ws_reg         <= ws_next;
            base_reg       <= base_next;
            last_ack_reg   <= last_ack_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
            scan_idx_reg   <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        chk_idx_reg   <= chk_idx_next;
        d_reg         <= d_next;
        pend_slot_reg <= pend_slot_next;
        pend_len_reg  <= pend_len_next;
        out_reg       <= out_next;
    end

`ifndef SYNTHESIS
    a_ws_range: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg < SW'(NS))
        else $error("window start outside the slot range");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, base_reg} < srw_pkg::SEQ_SPACE_V && {1'b0, last_ack_reg} < srw_pkg::SEQ_SPACE_V)
        else $error("base or last ack outside the sequence space");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (slot_valid_reg == '0) && (ws_reg == '0))
        else $error("configuration write did not start a new window");

    a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srw_pkg::ST_DEL_CHK) && !pend_vld_reg |-> hit)
        else $error("delivery run started without an in-order slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/selective_repeat_receive_window.sv =====
// Top level of the selective-repeat receive window: port packing around the
// front part (srw_front) and the back part (srw_back). Depends on srw_pkg.
`default_nettype none

// Each input beat is the header of one received segment. The front part
// reduces the sequence and ack numbers into the sequence space, saturates the
// length to one segment and queues the header in a two-entry queue, so the
// sender can hand over the next header while the back part is still busy.
// The back part checks the header against a circular window of ten slots:
// it reads the slot store one slot a cycle to find a pending copy, then sends
// a new ack, a duplicate re-ack, or nothing for a segment outside the window.
// A stored segment that lands on the window base starts a run of in-order
// deliveries, each advancing the base by its length. A FIN header is answered
// with a FIN ack of the last ack plus one. A data header is taken, then the
// slot scan reads all ten slots through the store's single read port, the
// compare pipeline drains and the header is classified. A run of in-order
// deliveries takes a read of the store followed by its check for each
// delivery, and one more read and check that finds the next slot not in
// order and ends the run. Stalls on the result side can hold the classify,
// FIN and delivery steps. The slot-valid marks clear at reset and on a write
// of the base register, which also loads the base and last ack; write it only
// while the block has no header in flight.
module selective_repeat_receive_window (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Base register write.
    input  wire logic                          cfg_wr_en,
    input  wire logic [srw_pkg::SEQ_W-1:0]     cfg_wr_data,
    // Header beats in.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: seq_num[14:0], peer_ack_num[29:15], seg_length[39:30]
    input  wire logic [srw_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: fin_flag[0]
    input  wire logic [0:0]                    s_tuser,
    // Result beats out.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: ack_value[14:0], own_seq[29:15], slot_index[33:30],
    //          deliver_length[43:34], zero fill[47:44]
    output logic [srw_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: kind[1:0]
    output logic [srw_pkg::KIND_W-1:0]         m_tuser,
    output logic                               m_tlast
);

    logic             q_valid;
    logic             q_ready;
    srw_pkg::seg_t    q_seg;
    srw_pkg::result_t res;

    srw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_seg    (q_seg)
    );

    srw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_seg       (q_seg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    // Result fields packed from the lowest bit up, zero filled to whole bytes.
    assign m_tdata = {{srw_pkg::M_PAD_W{1'b0}}, res.dlen, res.slot, res.own, res.ack};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

// ===== tb/tb_selective_repeat_receive_window.sv =====
// Self-checking testbench for the selective-repeat receive window.
// Drives segment header beats, predicts every result beat with its own window
// model and checks them in order. Depends on srw_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_selective_repeat_receive_window;

    import srw_pkg::*;

    // Cycles in which no beat moves on either side before the run is called hung.
    // The longest quiet stretch of a correct run is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 400;
    // Quiet time after the last expected beat: up to three headers can still sit
    // in the block (two queued, one in the back part) when all of them drop.
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_PRINTED = 100;

    // One expected or observed result beat, at the widths of the block.
    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  ack;
        logic [SEQ_W-1:0]  own;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  dlen;
        logic              last;
    } window_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [SEQ_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    // Window model: slot contents, pending marks, base and last ack.
    logic [SEQ_W-1:0]  win_slot_seq [WINDOW_SLOTS];
    logic [LEN_W-1:0]  win_slot_len [WINDOW_SLOTS];
    logic              win_busy [WINDOW_SLOTS];
    logic [SLOT_W-1:0] win_start;
    logic [SEQ_W-1:0]  win_base;
    logic [SEQ_W-1:0]  win_last_ack;

    window_beat_t expected_beats [$];

    int error_count = 0;
    int headers_sent = 0;
    int beats_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    selective_repeat_receive_window i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------

    function automatic window_beat_t make_beat(input kind_t kind, input int ack, input int own,
                                               input int slot, input int dlen);
        window_beat_t b;
        b.kind = kind;
        b.ack  = SEQ_W'(ack);
        b.own  = SEQ_W'(own);
        b.slot = SLOT_W'(slot);
        b.dlen = LEN_W'(dlen);
        b.last = 1'b0;
        return b;
    endfunction

    // A base register write starts a fresh window at the reduced base.
    task automatic load_base(input logic [SEQ_W-1:0] value);
        int i;
        for (i = 0; i < WINDOW_SLOTS; i++)
        begin
            win_busy[i]     = 1'b0;
            win_slot_seq[i] = '0;
            win_slot_len[i] = '0;
        end
        win_start    = '0;
        win_base     = SEQ_W'(int'(value) % SEQ_SPACE);
        win_last_ack = win_base;
    endtask

    // Classifies one accepted header against the window and queues the beats
    // it must produce: an ack of some kind unless it drops, then any in-order deliveries.
    task automatic classify_segment(input logic [SEQ_W-1:0] seq_raw,
                                    input logic [SEQ_W-1:0] own_raw,
                                    input logic [LEN_W-1:0] len_raw, input logic fin);
        window_beat_t beats [WINDOW_SLOTS + 1];
        int count, seq, own, len, gap, slot, i, head;
        bit dup, store, dropped;
        count   = 0;
        dup     = 1'b0;
        store   = 1'b0;
        dropped = 1'b0;
        slot    = 0;
        seq     = int'(seq_raw) % SEQ_SPACE;
        own     = int'(own_raw) % SEQ_SPACE;
        len     = (int'(len_raw) > SEGMENT_BYTES) ? SEGMENT_BYTES : int'(len_raw);
        if (fin)
        begin
            // A finish request leaves the window alone and bumps the last ack.
            win_last_ack = SEQ_W'((int'(win_last_ack) + 1) % SEQ_SPACE);
            beats[0] = make_beat(KIND_FIN_ACK, win_last_ack, own, 0, 0);
            count = 1;
        end
        else
        begin
            for (i = 0; i < WINDOW_SLOTS; i++)
                if (win_busy[i] && int'(win_slot_seq[i]) == seq)
                    dup = 1'b1;
            gap = (seq + SEQ_SPACE - int'(win_base)) % SEQ_SPACE;
            if (!dup)
            begin
                if (gap < SPAN)
                begin
                    // Unaligned offsets round down to the slot they start in.
                    slot = (int'(win_start) + gap / SEGMENT_BYTES) % WINDOW_SLOTS;
                    if (win_busy[slot])
                        dup = 1'b1;
                    else
                        store = (len != 0);
                end
                else if (gap + SPAN >= SEQ_SPACE)
                    dup = 1'b1;  // up to one window behind the base
                else
                    dropped = 1'b1;
            end
            if (!dropped)
            begin
                win_last_ack = SEQ_W'((seq + len) % SEQ_SPACE);
                if (dup)
                    beats[0] = make_beat(KIND_DUP_ACK, win_last_ack, own, 0, 0);
                else
                    beats[0] = make_beat(KIND_NEW_ACK, win_last_ack, own, store ? slot : 0, 0);
                count = 1;
                if (store)
                begin
                    win_slot_seq[slot] = SEQ_W'(seq);
                    win_slot_len[slot] = LEN_W'(len);
                    win_busy[slot]     = 1'b1;
                    head = int'(win_start);
                    while (count < WINDOW_SLOTS + 1 && win_busy[head] &&
                           win_slot_seq[head] == win_base)
                    begin
                        beats[count] = make_beat(KIND_DELIVER, 0, 0, head,
                                                 int'(win_slot_len[head]));
                        count++;
                        win_busy[head] = 1'b0;
                        win_base  = SEQ_W'((int'(win_base) + int'(win_slot_len[head])) %
                                           SEQ_SPACE);
                        head      = (head + 1) % WINDOW_SLOTS;
                        win_start = SLOT_W'(head);
                    end
                end
            end
        end
        for (i = 0; i < count; i++)
        begin
            beats[i].last = (i == count - 1);
            expected_beats.push_back(beats[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one header beat and returns in the step in which it was accepted.
    // The valid is left high so that the next header can follow without a gap.
    task automatic send_header(input int seq, input int own, input int len, input bit fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {LEN_W'(len), SEQ_W'(own), SEQ_W'(seq)};
        s_tuser  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        headers_sent++;
        classify_segment(SEQ_W'(seq), SEQ_W'(own), LEN_W'(len), fin);
    endtask

    // Drops the valid, waits for every expected beat and lets the block settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the base register; only called with the block idle.
    task automatic write_base(input logic [SEQ_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        load_base(value);
    endtask

    // Small sequence numbers also have an out-of-range alias that must reduce
    // to the same number.
    function automatic int alias_seq(input int value);
        if (value < (1 << SEQ_W) - SEQ_SPACE && $urandom_range(0, 3) == 0)
            return value + SEQ_SPACE;
        return value;
    endfunction

    function automatic int random_ack();
        return $urandom_range(0, (1 << SEQ_W) - 1);
    endfunction

    // Sends the next k segments of the stream from the current base, in a
    // shuffled order. All but the last are full size; the last is of any length.
    task automatic send_stream_group(input int k);
        int order [WINDOW_SLOTS];
        int j, pick, tmp, start, offs, len;
        for (j = 0; j < k; j++)
            order[j] = j;
        for (j = k - 1; j > 0; j--)
        begin
            pick = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[pick];
            order[pick] = tmp;
        end
        start = int'(win_base);
        for (j = 0; j < k; j++)
        begin
            offs = order[j];
            if (offs == k - 1 && $urandom_range(0, 3) == 0)
                len = $urandom_range(0, (1 << LEN_W) - 1);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(SEGMENT_BYTES, (1 << LEN_W) - 1);
            else
                len = SEGMENT_BYTES;
            send_header(alias_seq((start + offs * SEGMENT_BYTES) % SEQ_SPACE),
                        random_ack(), len, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each classification path once from a zero base: in-order delivery, a
    // stored gap, a pending duplicate, a long segment that releases two slots,
    // a segment behind the base, an empty segment with an out-of-range number,
    // a drop, a finish, an unaligned segment, an occupied slot and the far end
    // of the window.
    task automatic test_directed_window();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_base(SEQ_W'(0));
        send_header(0, 0, SEGMENT_BYTES, 1'b0);
        send_header(1024, 100, SEGMENT_BYTES, 1'b0);
        send_header(1024, 101, SEGMENT_BYTES, 1'b0);
        send_header(512, 102, (1 << LEN_W) - 1, 1'b0);
        send_header(0, 103, SEGMENT_BYTES, 1'b0);
        send_header((1 << SEQ_W) - 2767, 104, 0, 1'b0);
        send_header(20000, 105, 100, 1'b0);
        send_header(20000, (1 << SEQ_W) - 1, 0, 1'b1);
        send_header(1636, 106, 10, 1'b0);
        send_header(1536, 107, SEGMENT_BYTES, 1'b0);
        send_header(6144, 108, SEGMENT_BYTES, 1'b0);
        send_header(6656, 109, SEGMENT_BYTES, 1'b0);
        wait_for_results();
    endtask

    // A full window filled back to front from the top of the sequence space:
    // the numbers wrap, and the last header releases ten deliveries at once.
    task automatic test_window_wrap();
        int k;
        write_base(SEQ_W'(SEQ_SPACE - 1));
        for (k = WINDOW_SLOTS - 1; k >= 0; k--)
            send_header(alias_seq((SEQ_SPACE - 1 + k * SEGMENT_BYTES) % SEQ_SPACE),
                        random_ack(), SEGMENT_BYTES, 1'b0);
        send_header((1 << SEQ_W) - 1, 0, (1 << LEN_W) - 1, 1'b1);
        send_header(0, SEQ_SPACE - 1, 0, 1'b1);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while headers keep coming, so
    // the input queue fills and the block stalls its input. The sender then
    // pauses until every expected beat is in.
    task automatic test_receiver_backpressure();
        int stop_at;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_base(SEQ_W'($urandom_range(0, (1 << SEQ_W) - 1)));
        hold_arm = 1'b1;
        stop_at = headers_sent + 25;
        while (headers_sent < stop_at)
            send_stream_group($urandom_range(4, WINDOW_SLOTS));
        wait_for_results();
    endtask

    // Mostly well-formed stream traffic with random content, mixed with
    // resends, finishes and raw noise, under one idling setting and starting base.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int base_value, input int count);
        int stop_at, pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_base(SEQ_W'(base_value));
        stop_at = headers_sent + count;
        while (headers_sent < stop_at)
        begin
            // A stray segment parked at the window head blocks delivery for good;
            // start a new window when that happens.
            if (win_busy[win_start] && win_slot_seq[win_start] != win_base)
            begin
                wait_for_results();
                write_base(SEQ_W'($urandom_range(0, (1 << SEQ_W) - 1)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_stream_group($urandom_range(1, WINDOW_SLOTS));
            else if (pick < 76)
                send_header(alias_seq((int'(win_base) + SEQ_SPACE -
                                       $urandom_range(1, WINDOW_SLOTS) * SEGMENT_BYTES) %
                                      SEQ_SPACE),
                            random_ack(), SEGMENT_BYTES, 1'b0);
            else if (pick < 82)
                send_header(random_ack(), random_ack(),
                            $urandom_range(0, (1 << LEN_W) - 1), 1'b1);
            else if (pick < 88)
                send_header(alias_seq((int'(win_base) + $urandom_range(0, WINDOW_SLOTS - 1) *
                                       SEGMENT_BYTES) % SEQ_SPACE),
                            random_ack(), SEGMENT_BYTES, 1'b0);
            else if (pick < 92)
                send_header((int'(win_base) + $urandom_range(0, SPAN - 1)) % SEQ_SPACE,
                            random_ack(), $urandom_range(0, (1 << LEN_W) - 1), 1'b0);
            else
                send_header($urandom_range(0, (1 << SEQ_W) - 1), random_ack(),
                            $urandom_range(0, (1 << LEN_W) - 1), 1'b0);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // The ready follows the stall percentage, except during the one long
    // hold-off, which this process counts down by itself.
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("%0t: result beat %0d, %s: got %0d, expected %0d",
                     $realtime, beats_seen, field, got, want);
        error_count++;
    endtask

    // Every accepted result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        window_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("beat with nothing expected, kind", int'(m_tuser), -1);
            else
            begin
                want = expected_beats.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", int'(m_tuser), int'(want.kind));
                if (m_tdata[14:0] !== want.ack)
                    report_mismatch("ack_value", int'(m_tdata[14:0]), int'(want.ack));
                if (m_tdata[29:15] !== want.own)
                    report_mismatch("own_seq", int'(m_tdata[29:15]), int'(want.own));
                if (m_tdata[33:30] !== want.slot)
                    report_mismatch("slot_index", int'(m_tdata[33:30]), int'(want.slot));
                if (m_tdata[43:34] !== want.dlen)
                    report_mismatch("deliver_length", int'(m_tdata[43:34]), int'(want.dlen));
                if (m_tdata[47:44] !== 4'd0)
                    report_mismatch("zero fill", int'(m_tdata[47:44]), 0);
                if (m_tlast !== want.last)
                    report_mismatch("last", int'(m_tlast), int'(want.last));
            end
            beats_seen++;
        end
    end

    // Ends a hung run: nothing accepted on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $realtime, quiet_cycles);
            $display("[selective_repeat_receive_window] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        load_base(SEQ_W'(0));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_window();
        test_window_wrap();
        test_receiver_backpressure();
        test_random_traffic(0, 0, (1 << SEQ_W) - 1, 80);
        test_random_traffic(54, 0, $urandom_range(0, (1 << SEQ_W) - 1), 80);
        test_random_traffic(0, 54, SEQ_SPACE - 1, 80);
        test_random_traffic(6, 6, 0, 80);

        if (error_count == 0)
            $display("[selective_repeat_receive_window] OK");
        else
            $display("[selective_repeat_receive_window] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/srw_pkg.sv
rtl/srw_ram.sv
rtl/srw_front.sv
rtl/srw_back.sv
rtl/selective_repeat_receive_window.sv
tb/tb_selective_repeat_receive_window.sv
